// ----- hdl/signed_int_to_decimal_ascii_core_assert.svh -----
// Assertion macros shared by the checker of the decimal text core.
// Plain header: no dependencies, guarded against double inclusion.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// same-cycle implication
`define ITOA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itoa assertion failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itoa assertion failed");

`endif

// ----- hdl/itoa_pkg.sv -----
// Shared constants and controller/datapath interface types for the decimal text core.
// No dependencies.
`default_nettype none

package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   // magnitude bits consumed per conversion cycle (shift-add-3 steps per cycle)
   localparam int STEP_BITS   = 8;
   localparam int NUM_STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_WIDTH   = NUM_STEPS * STEP_BITS;
   // floor(W*log10(2)) + 1 decimal digits cover any W-bit magnitude
   localparam int NUM_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_WIDTH   = NUM_DIGITS * 4;
   localparam int DIGIT_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int STEP_CNT_W  = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

   localparam int CHAR_WIDTH      = 8;
   localparam int COUNT_WIDTH     = 4;
   localparam int REQ_DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH  = ((CHAR_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;

   typedef struct packed {
      logic load;       // capture input, take magnitude
      logic step;       // one conversion cycle
      logic count;      // find leading digit, latch char count
      logic emit_sign;  // output shows the minus sign
      logic advance;    // move to next lower digit
   } itoa_cmd_type;

   typedef struct packed {
      logic negative;
      logic last_digit;
   } itoa_status_type;

endpackage

`default_nettype wire

// ----- hdl/itoa_ctrl.sv -----
// Sequencer of the decimal text core: load, convert, count, then emit characters.
// Depends on itoa_pkg.
`default_nettype none

module itoa_ctrl
   import itoa_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire itoa_status_type status,
   output itoa_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CONV  = 3'd1;
   localparam logic [2:0] S_COUNT = 3'd2;
   localparam logic [2:0] S_SIGN  = 3'd3;
   localparam logic [2:0] S_DIGIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic                  rsp_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SIGN) || (state_ff == S_DIGIT);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(NUM_STEPS - 1)) begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.count = 1'b1;
            state_in  = status.negative ? S_SIGN : S_DIGIT;
         end
         S_SIGN: begin
            cmd.emit_sign = 1'b1;
            if (rsp_fire) begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (rsp_fire) begin
               if (status.last_digit) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/itoa_dpath.sv -----
// Datapath of the decimal text core: magnitude, shift-add-3 BCD conversion,
// leading digit search and character formatting. Depends on itoa_pkg.
`default_nettype none

module itoa_dpath
   import itoa_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [VALUE_WIDTH-1:0] value,
   input  wire itoa_cmd_type           cmd,
   output itoa_status_type             status,
   output logic [CHAR_WIDTH-1:0]       character,
   output logic                        last,
   output logic [COUNT_WIDTH-1:0]      char_count
);

   logic [PAD_WIDTH-1:0]   mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   logic [VALUE_WIDTH-1:0] magnitude;
   logic [PAD_WIDTH-1:0]   mag_step;
   logic [BCD_WIDTH-1:0]   bcd_step;
   logic [DIGIT_IDX_W-1:0] msd;
   logic [3:0]             digit;

   // two's complement magnitude, wraps so the most negative value is exact
   assign magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

   // STEP_BITS shift-add-3 steps, MSB of the magnitude first
   always_comb begin
      logic [BCD_WIDTH-1:0] b;
      logic [PAD_WIDTH-1:0] m;
      b = bcd_ff;
      m = mag_ff;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
               b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
         end
         b = {b[BCD_WIDTH-2:0], m[PAD_WIDTH-1]};
         m = {m[PAD_WIDTH-2:0], 1'b0};
      end
      bcd_step = b;
      mag_step = m;
   end

   // highest nonzero digit; zero keeps digit 0
   always_comb begin
      msd = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            msd = DIGIT_IDX_W'(d);
         end
      end
   end

   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      if (cmd.load) begin
         mag_in = PAD_WIDTH'(magnitude);
         bcd_in = '0;
         neg_in = value[VALUE_WIDTH-1];
      end
      if (cmd.step) begin
         mag_in = mag_step;
         bcd_in = bcd_step;
      end
      if (cmd.count) begin
         idx_in   = msd;
         total_in = COUNT_WIDTH'(msd) + COUNT_WIDTH'(1) + COUNT_WIDTH'(neg_ff);
      end
      if (cmd.advance) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      bcd_ff   <= bcd_in;
      neg_ff   <= neg_in;
      idx_ff   <= idx_in;
      total_ff <= total_in;
   end

   assign digit = bcd_ff[idx_ff*4 +: 4];

   assign status.negative   = neg_ff;
   assign status.last_digit = (idx_ff == '0);

   always_comb begin
      if (cmd.emit_sign) begin
         character  = CHAR_MINUS;
         last       = 1'b0;
         char_count = '0;
      end else begin
         character  = CHAR_ZERO + CHAR_WIDTH'(digit);
         last       = (idx_ff == '0);
         char_count = (idx_ff == '0) ? total_ff : '0;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/signed_int_to_decimal_ascii_core.sv -----
// Signed integer to decimal ASCII text. Each request transfer carries one signed
// 32-bit value; the core answers with its decimal text, one character per
// response transfer, most significant first: a leading '-' for negative values,
// no leading zeros, a lone '0' for zero, and -2147483648 printed exactly. The
// final character has rsp_tlast high and carries the character count (1..11) in
// rsp_tdata[11:8]; every other character carries 0 there. One value is handled
// at a time: after the request transfer the core converts the magnitude
// (8 magnitude bits per cycle through the shift-add-3 BCD unit), then locates
// the leading digit and presents n characters, one per cycle while rsp_tready
// is high. req_tready stays low until the last character has been transferred.
// Depends on itoa_pkg, itoa_ctrl and itoa_dpath.
`default_nettype none

module signed_int_to_decimal_ascii_core
   import itoa_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,  // [31:0] value (signed)
   // response channel
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,  // [7:0] character, [11:8] char_count, rest 0
   output logic                           rsp_tlast   // last character of the number
);

   itoa_cmd_type           cmd;
   itoa_status_type        status;
   logic [CHAR_WIDTH-1:0]  character;
   logic [COUNT_WIDTH-1:0] char_count;

   // sequencer: owns both handshakes
   itoa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // conversion and formatting; holds its registers until the next command
   itoa_dpath u_dpath (
      .clock      (clock),
      .value      (req_tdata[VALUE_WIDTH-1:0]),
      .cmd        (cmd),
      .status     (status),
      .character  (character),
      .last       (rsp_tlast),
      .char_count (char_count)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'({char_count, character});

endmodule

`default_nettype wire

// ----- hdl/itoa_checker.sv -----
// Port-level checks for the decimal text core, bound to the top level.
// Depends on itoa_pkg and signed_int_to_decimal_ascii_core_assert.svh.
`default_nettype none
`include "signed_int_to_decimal_ascii_core_assert.svh"

module itoa_checker
   import itoa_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic                      rsp_tlast
);

   // response held while stalled
   `ITOA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // one number at a time: no request taken while text is pending
   `ITOA_ASSERT_IMPLY(a_no_overlap, clock, reset, req_tready, !rsp_tvalid)
   // after a request transfer the core is busy
   `ITOA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // count appears only on the last character, and is never zero there
   `ITOA_ASSERT_IMPLY(a_count_on_last, clock, reset, rsp_tvalid, (rsp_tdata[CHAR_WIDTH +: COUNT_WIDTH] != '0) == rsp_tlast)

endmodule

bind signed_int_to_decimal_ascii_core itoa_checker u_itoa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
